>>> hdl/pje_pkg.sv
// Shared types, event and state codes, and the transition table of the print job event machine.
// Depends on nothing; every other file in hdl/ uses it by scoped names.
`default_nettype none

package pje_pkg;

  typedef logic [4:0] ev_t;
  typedef logic [3:0] st_t;
  typedef logic [1:0] stat_t;

  // Event codes that appear in the transition table.
  localparam ev_t EV_INIT          = 5'd0;
  localparam ev_t EV_JOB_SUBMITTED = 5'd3;
  localparam ev_t EV_JOB_START     = 5'd4;
  localparam ev_t EV_JOB_PROGRESS  = 5'd5;
  localparam ev_t EV_JOB_PAUSE     = 5'd6;
  localparam ev_t EV_JOB_RESUME    = 5'd7;
  localparam ev_t EV_JOB_CANCEL    = 5'd8;
  localparam ev_t EV_JOB_COMPLETE  = 5'd9;
  localparam ev_t EV_HW_ERROR      = 5'd10;
  localparam ev_t EV_REFILL_PAPER  = 5'd15;
  localparam ev_t EV_REFILL_TONER  = 5'd16;
  localparam ev_t EV_CLEAR_ERROR   = 5'd17;
  localparam ev_t EV_CYCLE         = 5'd20;

  // Machine states that appear in the transition table.
  localparam st_t ST_INIT          = 4'd0;
  localparam st_t ST_RESET         = 4'd1;
  localparam st_t ST_IDLE          = 4'd2;
  localparam st_t ST_PRINT_START   = 4'd4;
  localparam st_t ST_PRINT_RUNNING = 4'd5;
  localparam st_t ST_PRINT_PAGE    = 4'd6;
  localparam st_t ST_PRINT_PAUSE   = 4'd7;
  localparam st_t ST_PRINT_RESUME  = 4'd8;
  localparam st_t ST_PRINT_FINISH  = 4'd9;
  localparam st_t ST_ERROR         = 4'd10;
  localparam st_t ST_ERROR_RECOV   = 4'd11;
  localparam st_t ST_MAINTENANCE   = 4'd13;

  // Printer status codes.
  localparam stat_t STAT_IDLE     = 2'd0;
  localparam stat_t STAT_PRINTING = 2'd1;
  localparam stat_t STAT_PAUSED   = 2'd2;
  localparam stat_t STAT_ERROR    = 2'd3;

  typedef enum logic [3:0] {
    ACT_NONE, ACT_CHECK, ACT_START, ACT_PAGE, ACT_PAUSE, ACT_RESUME,
    ACT_FINISH, ACT_ERROR, ACT_RECOVER, ACT_PAPER, ACT_TONER
  } act_e;

  typedef struct packed {
    logic hit;
    st_t  to;
    act_e act;
  } trans_t;

  typedef struct packed {
    ev_t  action;
    logic hw_fault;
    logic task_present;
  } req_t;

  typedef struct packed {
    logic        matched;
    st_t         prev_state;
    st_t         new_state;
    stat_t       printer_status;
    logic [15:0] job_pages;
    logic [31:0] total_pages;
    logic [15:0] fault_count;
    logic        paper_refilled;
    logic        toner_refilled;
    logic        self_raised;
    logic [31:0] events_seen;
    logic        last;
  } rsp_t;

  function automatic trans_t hit_to(st_t to, act_e act);
    trans_t t;
    t.hit = 1'b1;
    t.to  = to;
    t.act = act;
    return t;
  endfunction

  // Transition table: one arm per (state, event) pair that fires.
  function automatic trans_t lookup(st_t from, ev_t ev);
    trans_t t;
    unique case ({from, ev})
      {ST_INIT,          EV_INIT}:          t = hit_to(ST_RESET, ACT_NONE);
      {ST_RESET,         EV_CYCLE}:         t = hit_to(ST_IDLE, ACT_NONE);
      {ST_IDLE,          EV_JOB_SUBMITTED}: t = hit_to(ST_PRINT_START, ACT_CHECK);
      {ST_IDLE,          EV_HW_ERROR}:      t = hit_to(ST_ERROR, ACT_ERROR);
      {ST_IDLE,          EV_REFILL_PAPER}:  t = hit_to(ST_MAINTENANCE, ACT_PAPER);
      {ST_IDLE,          EV_REFILL_TONER}:  t = hit_to(ST_MAINTENANCE, ACT_TONER);
      {ST_MAINTENANCE,   EV_CYCLE}:         t = hit_to(ST_IDLE, ACT_NONE);
      {ST_MAINTENANCE,   EV_HW_ERROR}:      t = hit_to(ST_ERROR, ACT_ERROR);
      {ST_PRINT_START,   EV_JOB_START}:     t = hit_to(ST_PRINT_RUNNING, ACT_START);
      {ST_PRINT_START,   EV_HW_ERROR}:      t = hit_to(ST_ERROR, ACT_ERROR);
      {ST_PRINT_RUNNING, EV_JOB_PROGRESS}:  t = hit_to(ST_PRINT_PAGE, ACT_PAGE);
      {ST_PRINT_RUNNING, EV_JOB_PAUSE}:     t = hit_to(ST_PRINT_PAUSE, ACT_PAUSE);
      {ST_PRINT_RUNNING, EV_JOB_COMPLETE}:  t = hit_to(ST_PRINT_FINISH, ACT_FINISH);
      {ST_PRINT_RUNNING, EV_HW_ERROR}:      t = hit_to(ST_ERROR, ACT_ERROR);
      {ST_PRINT_RUNNING, EV_JOB_CANCEL}:    t = hit_to(ST_IDLE, ACT_NONE);
      {ST_PRINT_PAGE,    EV_JOB_PROGRESS}:  t = hit_to(ST_PRINT_RUNNING, ACT_NONE);
      {ST_PRINT_PAGE,    EV_JOB_COMPLETE}:  t = hit_to(ST_PRINT_FINISH, ACT_FINISH);
      {ST_PRINT_PAGE,    EV_HW_ERROR}:      t = hit_to(ST_ERROR, ACT_ERROR);
      {ST_PRINT_PAUSE,   EV_JOB_RESUME}:    t = hit_to(ST_PRINT_RESUME, ACT_RESUME);
      {ST_PRINT_PAUSE,   EV_JOB_CANCEL}:    t = hit_to(ST_IDLE, ACT_NONE);
      {ST_PRINT_PAUSE,   EV_HW_ERROR}:      t = hit_to(ST_ERROR, ACT_ERROR);
      {ST_PRINT_RESUME,  EV_JOB_PROGRESS}:  t = hit_to(ST_PRINT_RUNNING, ACT_NONE);
      {ST_PRINT_FINISH,  EV_CYCLE}:         t = hit_to(ST_IDLE, ACT_NONE);
      {ST_ERROR,         EV_CLEAR_ERROR}:   t = hit_to(ST_ERROR_RECOV, ACT_RECOVER);
      {ST_ERROR,         EV_REFILL_PAPER}:  t = hit_to(ST_MAINTENANCE, ACT_PAPER);
      {ST_ERROR,         EV_REFILL_TONER}:  t = hit_to(ST_MAINTENANCE, ACT_TONER);
      {ST_ERROR_RECOV,   EV_CYCLE}:         t = hit_to(ST_IDLE, ACT_NONE);
      default: begin
        t.hit = 1'b0;
        t.to  = from;
        t.act = ACT_NONE;
      end
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

>>> hdl/pje_if.sv
// Valid/ready channel interfaces for event requests and result items.
// Depends on pje_pkg for the field types.
`default_nettype none

interface pje_req_if;
  logic          valid;
  logic          ready;
  pje_pkg::ev_t  action;
  logic          hw_fault;
  logic          task_present;

  modport source (output valid, action, hw_fault, task_present, input ready);
  modport sink   (input valid, action, hw_fault, task_present, output ready);
endinterface

interface pje_rsp_if;
  logic          valid;
  logic          ready;
  logic          matched;
  pje_pkg::st_t  prev_state;
  pje_pkg::st_t  new_state;
  pje_pkg::stat_t printer_status;
  logic [15:0]   job_pages;
  logic [31:0]   total_pages;
  logic [15:0]   fault_count;
  logic          paper_refilled;
  logic          toner_refilled;
  logic          self_raised;
  logic [31:0]   events_seen;
  logic          last;

  modport source (output valid, matched, prev_state, new_state, printer_status, job_pages,
                  total_pages, fault_count, paper_refilled, toner_refilled, self_raised,
                  events_seen, last, input ready);
  modport sink   (input valid, matched, prev_state, new_state, printer_status, job_pages,
                  total_pages, fault_count, paper_refilled, toner_refilled, self_raised,
                  events_seen, last, output ready);
endinterface

`default_nettype wire

>>> hdl/pje_in_reg.sv
// Input register for event requests; refills in the same cycle it is drained.
// Depends on pje_pkg for the request type.
`default_nettype none

module pje_in_reg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  output logic               ready_o,
  input  wire pje_pkg::req_t data_i,
  output logic               valid_o,
  input  wire logic          pop_i,
  output pje_pkg::req_t      data_o
);

  logic          valid_q, valid_d;
  pje_pkg::req_t data_q;

  // Room whenever empty or emptied in this cycle.
  assign ready_o = !valid_q || pop_i;
  assign valid_d = (valid_i && ready_o) || (valid_q && !pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

>>> hdl/pje_core.sv
// Event machine: status, counters, result register; one transition per unstalled cycle.
// Depends on pje_pkg for codes, the transition table and the payload types.
`default_nettype none

module pje_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire pje_pkg::req_t in_data_i,
  output logic               in_pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output pje_pkg::rsp_t      out_data_o
);

  pje_pkg::st_t   state_q, state_d;
  pje_pkg::stat_t status_q, status_d;
  logic [15:0]    job_q, job_d;
  logic [31:0]    total_q, total_d;
  logic [15:0]    err_q, err_d;
  logic [31:0]    evcnt_q, evcnt_d;
  logic           pend_q, pend_d;
  logic           out_valid_q, out_valid_d;
  pje_pkg::rsp_t  out_q, out_d;

  pje_pkg::ev_t   ev;
  pje_pkg::trans_t tr;
  logic           fire;
  logic           raise;
  logic           paper;
  logic           toner;
  logic [32:0]    total_sum;

  // A step runs when there is work and the result register can take it.
  assign fire     = (pend_q || in_valid_i) && (!out_valid_q || out_ready_i);
  assign in_pop_o = fire && !pend_q;

  // A pending self-raised error goes ahead of the next request.
  assign ev        = pend_q ? pje_pkg::EV_HW_ERROR : in_data_i.action;
  assign tr        = pje_pkg::lookup(state_q, ev);
  assign total_sum = {1'b0, total_q} + {17'd0, job_q};

  // Action of the fired transition.
  always_comb begin
    status_d = status_q;
    job_d    = job_q;
    total_d  = total_q;
    err_d    = err_q;
    raise    = 1'b0;
    paper    = 1'b0;
    toner    = 1'b0;
    unique case (tr.act)
      pje_pkg::ACT_CHECK: begin
        job_d = 16'd0;
        raise = in_data_i.hw_fault && !pend_q;
      end
      pje_pkg::ACT_START, pje_pkg::ACT_RESUME: begin
        status_d = pje_pkg::STAT_PRINTING;
      end
      pje_pkg::ACT_PAGE: begin
        if (in_data_i.task_present && job_q != 16'hFFFF) begin
          job_d = job_q + 16'd1;
        end
      end
      pje_pkg::ACT_PAUSE: begin
        status_d = pje_pkg::STAT_PAUSED;
      end
      pje_pkg::ACT_FINISH: begin
        status_d = pje_pkg::STAT_IDLE;
        if (in_data_i.task_present) begin
          total_d = total_sum[32] ? 32'hFFFF_FFFF : total_sum[31:0];
        end
      end
      pje_pkg::ACT_ERROR: begin
        status_d = pje_pkg::STAT_ERROR;
        if (err_q != 16'hFFFF) begin
          err_d = err_q + 16'd1;
        end
      end
      pje_pkg::ACT_RECOVER: begin
        status_d = pje_pkg::STAT_IDLE;
      end
      pje_pkg::ACT_PAPER: begin
        paper = 1'b1;
      end
      pje_pkg::ACT_TONER: begin
        toner = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign state_d = tr.to;
  assign evcnt_d = (evcnt_q != 32'hFFFF_FFFF) ? evcnt_q + 32'd1 : evcnt_q;
  assign pend_d  = fire ? raise : pend_q;
  assign out_valid_d = fire || (out_valid_q && !out_ready_i);

  // Result of this step.
  always_comb begin
    out_d.matched        = tr.hit;
    out_d.prev_state     = state_q;
    out_d.new_state      = state_d;
    out_d.printer_status = status_d;
    out_d.job_pages      = job_d;
    out_d.total_pages    = total_d;
    out_d.fault_count    = err_d;
    out_d.paper_refilled = paper;
    out_d.toner_refilled = toner;
    out_d.self_raised    = pend_q;
    out_d.events_seen    = evcnt_d;
    out_d.last           = !raise;
  end

  // Machine state and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pje_pkg::ST_INIT;
      status_q    <= pje_pkg::STAT_IDLE;
      job_q       <= 16'd0;
      total_q     <= 32'd0;
      err_q       <= 16'd0;
      evcnt_q     <= 32'd0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (fire) begin
        state_q  <= state_d;
        status_q <= status_d;
        job_q    <= job_d;
        total_q  <= total_d;
        err_q    <= err_d;
        evcnt_q  <= evcnt_d;
      end
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // While a raised error waits, its first result sits in the result register.
  a_pend_holds_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (out_valid_q && !out_q.last))
    else $error("pending error without its first result held");

  // No request is taken while a raised error waits.
  a_pend_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !in_pop_o)
    else $error("request taken while a raised error is pending");

  // The raised error always lands in ERROR as a final result.
  a_raised_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && pend_q) |=> (out_q.self_raised && out_q.last
                          && out_q.new_state == pje_pkg::ST_ERROR && out_q.matched))
    else $error("self-raised result malformed");

  // Every step counts exactly one event unless the counter is saturated.
  a_event_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> (evcnt_q == $past(evcnt_q) + 32'd1 || evcnt_q == 32'hFFFF_FFFF))
    else $error("event counter did not advance");
`endif

endmodule

`default_nettype wire

>>> hdl/print_job_event_fsm_top.sv
// Top level of the print job event machine: input register feeding the event core.
// Depends on pje_pkg, the pje_req_if / pje_rsp_if interfaces, pje_in_reg and pje_core.
//
//   Channel  Direction  Payload                                    Handshake
//   req_i    in         action, hw_fault, task_present             valid / ready
//   rsp_o    out        matched .. events_seen, last (12 fields)   valid / ready
//
// One event per cycle is taken while the result sink keeps up; an accepted job submission
// with a hardware fault takes one more core step, for the raised error.
// A result is valid once its request has passed the input register, then the result register.
// The result register frees in the cycle it is taken, so a stalled sink holds back only
// the core; the input register still takes one more request.
// Reset is asynchronous and active low; it clears the state, the counters and both valids.
`default_nettype none

module print_job_event_fsm_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pje_req_if.sink   req_i,
  pje_rsp_if.source rsp_o
);

  pje_pkg::req_t in_data;
  pje_pkg::req_t core_data;
  pje_pkg::rsp_t out_data;
  logic          core_valid;
  logic          core_pop;

  assign in_data.action       = req_i.action;
  assign in_data.hw_fault     = req_i.hw_fault;
  assign in_data.task_present = req_i.task_present;

  pje_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (req_i.valid),
    .ready_o (req_i.ready),
    .data_i  (in_data),
    .valid_o (core_valid),
    .pop_i   (core_pop),
    .data_o  (core_data)
  );

  pje_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (core_valid),
    .in_data_i   (core_data),
    .in_pop_o    (core_pop),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .out_data_o  (out_data)
  );

  assign rsp_o.matched        = out_data.matched;
  assign rsp_o.prev_state     = out_data.prev_state;
  assign rsp_o.new_state      = out_data.new_state;
  assign rsp_o.printer_status = out_data.printer_status;
  assign rsp_o.job_pages      = out_data.job_pages;
  assign rsp_o.total_pages    = out_data.total_pages;
  assign rsp_o.fault_count    = out_data.fault_count;
  assign rsp_o.paper_refilled = out_data.paper_refilled;
  assign rsp_o.toner_refilled = out_data.toner_refilled;
  assign rsp_o.self_raised    = out_data.self_raised;
  assign rsp_o.events_seen    = out_data.events_seen;
  assign rsp_o.last           = out_data.last;

endmodule

`default_nettype wire
